FILE: rtl/b2d_pkg.sv
// Shared constants, types and helpers for the binary to digit register write block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package b2d_pkg;

    localparam int VALUE_W    = 32;   // width of the input number
    localparam int ADDR_W     = 4;    // driver register address width
    localparam int DATA_W     = 4;    // driver register data width
    localparam int DIGIT_W    = 4;    // one BCD digit
    localparam int DIGITS_DEF = 8;    // default number of display digits

    localparam logic [ADDR_W-1:0] SCAN_LIMIT_ADDR = 4'hB;

    // Status from the converter to the write sequencer.
    typedef struct packed {
        logic full;   // converted digits are held and waiting
        logic ovf;    // input was clamped to the largest shown number
    } b2d_res_t;

    // Largest number shown on n digits: 10^n - 1 (elaboration only).
    function automatic logic [VALUE_W-1:0] max_shown(input int n);
        logic [VALUE_W-1:0] m;
        m = 32'd1;
        for (int k = 0; k < n; k++)
        begin
            m = VALUE_W'(m * 32'd10);
        end
        return VALUE_W'(m - 32'd1);
    endfunction

endpackage

FILE: rtl/b2d_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Clamps values wider than DIGITS decimal digits. Uses b2d_pkg.
module b2d_dabble #(
    parameter int DIGITS = b2d_pkg::DIGITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [b2d_pkg::VALUE_W-1:0]            value,
    input  logic                                   take,
    output logic                                   idle,
    output b2d_pkg::b2d_res_t                      res,
    output logic [DIGITS*b2d_pkg::DIGIT_W-1:0]     bcd
);

    localparam int BCD_W  = DIGITS * b2d_pkg::DIGIT_W;
    localparam int STEP_W = $clog2(b2d_pkg::VALUE_W);
    localparam logic [b2d_pkg::VALUE_W-1:0] LIMIT = b2d_pkg::max_shown(DIGITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(b2d_pkg::VALUE_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [b2d_pkg::VALUE_W-1:0]   sh_reg, sh_next;
    logic [BCD_W-1:0]              bcd_reg, bcd_next;
    logic                          ovf_reg, ovf_next;
    logic [BCD_W-1:0]              bcd_adj;
    logic                          too_big;

    assign too_big = (value > LIMIT);

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
                    bcd_reg[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
                    bcd_reg[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sh_next    = sh_reg;
        bcd_next   = bcd_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sh_next    = too_big ? LIMIT : value;
                    ovf_next   = too_big;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (BCD_W > 1)
                begin
                    bcd_next = {bcd_adj[BCD_W-2:0], sh_reg[b2d_pkg::VALUE_W-1]};
                end
                sh_next   = {sh_reg[b2d_pkg::VALUE_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        sh_reg   <= sh_next;
        bcd_reg  <= bcd_next;
        ovf_reg  <= ovf_next;
    end

    assign idle     = (state_reg == ST_IDLE);
    assign res.full = (state_reg == ST_FULL);
    assign res.ovf  = ovf_reg;
    assign bcd      = bcd_reg;

endmodule

FILE: rtl/b2d_emit.sv
// Write sequencer: scan-limit write, then one digit write per digit, low digit first.
// Holds each write in an output register until taken. Uses b2d_pkg.
module b2d_emit #(
    parameter int DIGITS = b2d_pkg::DIGITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  b2d_pkg::b2d_res_t                      res,
    input  logic [DIGITS*b2d_pkg::DIGIT_W-1:0]     bcd,
    output logic                                   take,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [b2d_pkg::ADDR_W-1:0]             reg_address,
    output logic [b2d_pkg::DATA_W-1:0]             reg_data,
    output logic                                   last,
    output logic                                   overflow
);

    localparam int BCD_W = DIGITS * b2d_pkg::DIGIT_W;

    logic                          valid_reg;
    logic [b2d_pkg::ADDR_W-1:0]    addr_reg;
    logic [b2d_pkg::DATA_W-1:0]    data_reg;
    logic                          last_reg;
    logic                          ovf_reg;
    logic [BCD_W-1:0]              dig_reg;
    logic [b2d_pkg::ADDR_W-1:0]    idx_reg;
    logic [b2d_pkg::ADDR_W-1:0]    count_reg;
    logic [b2d_pkg::ADDR_W-1:0]    count_new;
    logic                          done_write;

    // Digit count: position of the highest nonzero digit, at least one.
    always_comb
    begin
        count_new = 4'd1;
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] != 4'd0)
            begin
                count_new = b2d_pkg::ADDR_W'(d + 1);
            end
        end
    end

    assign take       = res.full && !valid_reg;
    assign done_write = valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (done_write && last_reg)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            addr_reg  <= b2d_pkg::SCAN_LIMIT_ADDR;
            data_reg  <= count_new - 1'b1;
            last_reg  <= 1'b0;
            ovf_reg   <= res.ovf;
            dig_reg   <= bcd;
            idx_reg   <= 4'd1;
            count_reg <= count_new;
        end
        else if (done_write && !last_reg)
        begin
            // advance to the next digit write
            addr_reg <= idx_reg;
            data_reg <= dig_reg[b2d_pkg::DIGIT_W-1:0];
            last_reg <= (idx_reg == count_reg);
            dig_reg  <= dig_reg >> b2d_pkg::DIGIT_W;
            idx_reg  <= idx_reg + 1'b1;
        end
    end

    assign out_valid   = valid_reg;
    assign reg_address = addr_reg;
    assign reg_data    = data_reg;
    assign last        = last_reg;
    assign overflow    = ovf_reg;

endmodule

FILE: rtl/binary_to_digit_register_writes.sv
// Binary number to LED-driver register writes, top level. Uses b2d_pkg, b2d_dabble, b2d_emit.
// The first write (scan limit) appears once the converter has shifted in every input bit and
// handed its digits to the sequencer. A new request is taken only when the bit-serial converter
// is idle again (load, shifts, hand-off); a run of count + 1 writes then drains from the sequencer,
// and the converter holds its digits while a stalled run is still draining.
// Reset: asynchronous, active low; clears control state only, no clearing pass.
module binary_to_digit_register_writes #(
    parameter int DIGITS = b2d_pkg::DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [b2d_pkg::VALUE_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [b2d_pkg::ADDR_W-1:0]     reg_address,
    output logic [b2d_pkg::DATA_W-1:0]     reg_data,
    output logic                           last,
    output logic                           overflow
);

    logic                                  conv_idle;
    logic                                  conv_take;
    b2d_pkg::b2d_res_t                     conv_res;
    logic [DIGITS*b2d_pkg::DIGIT_W-1:0]    conv_bcd;

    // Take a new request whenever the converter is free. The previous run may
    // still be draining from the write sequencer, so conversion overlaps output.
    assign in_ready = conv_idle;

    // Clamp, then shift the number in one bit per cycle, building the BCD digits.
    b2d_dabble #(
        .DIGITS (DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_valid && in_ready),
        .value (value),
        .take  (conv_take),
        .idle  (conv_idle),
        .res   (conv_res),
        .bcd   (conv_bcd)
    );

    // Hold the converted digits until the sequencer is free, then drop them into
    // its digit shift register and emit the scan-limit and digit writes in order.
    b2d_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (conv_res),
        .bcd         (conv_bcd),
        .take        (conv_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .reg_address (reg_address),
        .reg_data    (reg_data),
        .last        (last),
        .overflow    (overflow)
    );

endmodule

FILE: dv/binary_to_digit_register_writes_test.sv
// Self-checking bench for binary_to_digit_register_writes: directed table, then random numbers.
// Depends on rtl/b2d_pkg.sv and rtl/binary_to_digit_register_writes.sv; predicts every write.
module binary_to_digit_register_writes_test;

    localparam int              DIGITS      = 8;
    localparam logic [31:0]     TOP_SHOWN   = 32'd99_999_999;   // largest number on 8 digits
    localparam int              RAND_ITEMS  = 195;
    localparam int              SETTLE      = 40;               // idle time after the drain, to catch stray writes
    localparam int              CYCLE_LIMIT = 250_000;
    localparam int              N_ROWS      = 25;

    // One register write on the driver bus.
    typedef struct packed {
        logic [b2d_pkg::ADDR_W-1:0] addr;
        logic [b2d_pkg::DATA_W-1:0] data;
        logic                       fin;
        logic                       ovf;
    } reg_write_t;

    // Directed row: typed rows carry a run whose digits are all the same value.
    typedef struct packed {
        logic [31:0] number;
        logic        typed;
        logic [3:0]  n_digits;
        logic [3:0]  digit;
        logic        ovf;
    } number_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [31:0] value     = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  reg_address;
    logic [3:0]  reg_data;
    logic        last;
    logic        overflow;

    reg_write_t  pending_writes[$];
    int          mismatches     = 0;
    int          requests_sent  = 0;
    int          writes_seen    = 0;
    int          clamped_runs   = 0;
    int          cycles         = 0;
    bit          steady         = 1'b0;   // both sides hold off idling while set

    number_row_t number_rows [N_ROWS] = '{
        '{32'd0,          1'b1, 4'd1, 4'd0, 1'b0},   // zero still shows one digit
        '{32'd1,          1'b1, 4'd1, 4'd1, 1'b0},
        '{32'd9,          1'b1, 4'd1, 4'd9, 1'b0},
        '{32'd10,         1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd99,         1'b1, 4'd2, 4'd9, 1'b0},
        '{32'd100,        1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd999,        1'b1, 4'd3, 4'd9, 1'b0},
        '{32'd1000,       1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd9999,       1'b1, 4'd4, 4'd9, 1'b0},
        '{32'd12345,      1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd99999,      1'b1, 4'd5, 4'd9, 1'b0},
        '{32'd999999,     1'b1, 4'd6, 4'd9, 1'b0},
        '{32'd1000000,    1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd9999999,    1'b1, 4'd7, 4'd9, 1'b0},
        '{32'd10000000,   1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd11111111,   1'b1, 4'd8, 4'd1, 1'b0},
        '{32'd12345678,   1'b0, 4'd0, 4'd0, 1'b0},
        '{32'd99999999,   1'b1, 4'd8, 4'd9, 1'b0},   // widest number that fits
        '{32'd100000000,  1'b1, 4'd8, 4'd9, 1'b1},   // first number that gets clamped
        '{32'h8000_0000,  1'b1, 4'd8, 4'd9, 1'b1},
        '{32'h7FFF_FFFF,  1'b1, 4'd8, 4'd9, 1'b1},
        '{32'h5555_5555,  1'b1, 4'd8, 4'd9, 1'b1},
        '{32'hAAAA_AAAA,  1'b1, 4'd8, 4'd9, 1'b1},
        '{32'hFFFF_FFFF,  1'b1, 4'd8, 4'd9, 1'b1},
        '{32'd98765432,   1'b0, 4'd0, 4'd0, 1'b0}
    };

    binary_to_digit_register_writes #(
        .DIGITS(DIGITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value(value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .reg_address(reg_address),
        .reg_data(reg_data),
        .last(last),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Abort the run once the total cycle count passes CYCLE_LIMIT, as when the block stops making progress.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycles, pending_writes.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] power_of_ten(input int n);
        logic [31:0] p;
        p = 32'd1;
        for (int k = 0; k < n; k++)
        begin
            p = p * 32'd10;
        end
        return p;
    endfunction

    // Queue the scan-limit write and then one write per decimal digit, low digit first.
    function automatic void predict_digit_writes(input logic [31:0] number);
        logic [31:0] shown;
        logic [31:0] rest;
        logic        clamped;
        int          n_digits;
        reg_write_t  w;
        clamped  = number > TOP_SHOWN;
        shown    = clamped ? TOP_SHOWN : number;
        n_digits = 1;
        rest     = shown;
        while (rest >= 32'd10)
        begin
            rest = rest / 32'd10;
            n_digits++;
        end
        w.addr = b2d_pkg::SCAN_LIMIT_ADDR;
        w.data = 4'(n_digits - 1);
        w.fin  = 1'b0;
        w.ovf  = clamped;
        pending_writes.push_back(w);
        for (int i = 0; i < n_digits; i++)
        begin
            w.addr = 4'(i + 1);
            w.data = 4'(shown % 32'd10);
            w.fin  = (i == n_digits - 1);
            w.ovf  = clamped;
            pending_writes.push_back(w);
            shown  = shown / 32'd10;
        end
    endfunction

    // Queue a run whose expected digits are typed in the table.
    function automatic void queue_typed_run(input number_row_t row);
        reg_write_t w;
        w.addr = b2d_pkg::SCAN_LIMIT_ADDR;
        w.data = row.n_digits - 4'd1;
        w.fin  = 1'b0;
        w.ovf  = row.ovf;
        pending_writes.push_back(w);
        for (int i = 1; i <= row.n_digits; i++)
        begin
            w.addr = 4'(i);
            w.data = row.digit;
            w.fin  = (i == row.n_digits);
            pending_writes.push_back(w);
        end
    endfunction

    // Present one request, with a random idle gap ahead of it, and hold it until taken.
    task automatic send_number(input number_row_t row);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < 25)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= row.number;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        // Request taken at this edge: record what it must produce.
        if (row.typed)
        begin
            queue_typed_run(row);
        end
        else
        begin
            predict_digit_writes(row.number);
        end
        requests_sent++;
    endtask

    // Pick a random number, weighted toward every digit count and its boundaries.
    function automatic logic [31:0] pick_number();
        int sel;
        int n;
        sel = $urandom_range(99);
        n   = $urandom_range(DIGITS, 1);
        if (sel < 15)
        begin
            return $urandom();   // mostly clamped, and spreads every bit
        end
        else if (sel < 30)
        begin
            return $urandom_range(1) ? power_of_ten(n) : power_of_ten(n) - 32'd1;
        end
        else
        begin
            return $urandom_range(power_of_ten(n) - 32'd1, (n == 1) ? 0 : power_of_ten(n - 1));
        end
    endfunction

    // Drop the receiver's ready on about a quarter of the cycles, never while steady.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 25);
    end

    // Compare each write taken from the block with the oldest prediction.
    always @(posedge clk)
    begin
        reg_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            writes_seen++;
            if (last && overflow)
            begin
                clamped_runs++;
            end
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: reg_address %0d reg_data %0d last %0b overflow %0b",
                       reg_address, reg_data, last, overflow);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (reg_address !== want.addr)
                begin
                    $error("reg_address: expected %0d, got %0d", want.addr, reg_address);
                    mismatches++;
                end
                if (reg_data !== want.data)
                begin
                    $error("reg_data: expected %0d, got %0d", want.data, reg_data);
                    mismatches++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0b, got %0b", want.fin, last);
                    mismatches++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        number_row_t row;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: digit-count edges, zero, clamping, alternating bit patterns.
        for (int r = 0; r < N_ROWS; r++)
        begin
            send_number(number_rows[r]);
        end

        // Random numbers; a stretch in the middle runs with no idling on either side.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            steady       = (i >= 80 && i < 140);
            row          = '0;
            row.number   = pick_number();
            row.typed    = 1'b0;
            send_number(row);
        end
        steady   = 1'b0;
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray write.
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d numbers and %0d register writes, %0d runs clamped to 8 digits",
                 requests_sent, writes_seen, clamped_runs);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
